@@ hdl/assert_macros.svh @@
// assertion macros shared by the bound search rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define SBS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sbs_pkg.sv @@
// shared types and constants of the sorted table bound search
// no dependencies
package sbs_pkg;

    localparam int CMD_W = 2;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int VAL_W = 32;
    // signed search bound, wide enough for count minus one going negative
    localparam int POS_W = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_LOWER = 2'd1,
        CMD_UPPER = 2'd2,
        CMD_FLOOR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] data_value;
        logic [IDX_W-1:0]        search_low;
        logic [IDX_W-1:0]        search_high;
    } request_t;

    typedef struct packed {
        logic [CNT_W-1:0]        result_index;
        logic signed [VAL_W-1:0] result_value;
        logic                    found;
    } result_t;

endpackage

@@ hdl/sbs_table.sv @@
// table storage: one write port, one read port with registered read data
// depends on sbs_pkg
module sbs_table
    import sbs_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [VAL_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [VAL_W-1:0] rd_data
);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/sbs_search.sv @@
// search sequencer: takes requests, writes the table, runs the halving probe
// depends on sbs_pkg, assert_macros.svh, drives the ports of sbs_table
`include "assert_macros.svh"
module sbs_search
    import sbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_W      = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CNT_W-1:0]        element_count,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  request_t                req,
    output logic                    res_valid,
    input  logic                    res_ready,
    output result_t                 res,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output logic signed [VAL_W-1:0] wr_data,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  logic signed [VAL_W-1:0] rd_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [POS_W-1:0] lo_reg, lo_next;
    logic signed [POS_W-1:0] hi_reg, hi_next;
    logic signed [POS_W-1:0] mid_reg, mid_next;
    logic signed [POS_W-1:0] n_reg, n_next;
    cmd_t                    cmd_reg, cmd_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        ans_idx_reg, ans_idx_next;
    logic signed [VAL_W-1:0] ans_val_reg, ans_val_next;
    logic                    hit_reg, hit_next;

    logic                    accept;
    logic [CNT_W-1:0]        n_eff;
    logic signed [POS_W-1:0] hi_in;
    logic signed [POS_W-1:0] n_m1;
    logic signed [POS_W-1:0] mid;
    logic                    range_empty;
    logic                    qual;

    assign accept = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);

    // count above the table depth acts as the depth
    assign n_eff = ({21'd0, element_count} > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : element_count;
    assign hi_in = $signed({{(POS_W-IDX_W){1'b0}}, req.search_high});
    assign n_m1  = $signed({{(POS_W-CNT_W){1'b0}}, n_eff}) - POS_W'(1);

    assign mid         = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign range_empty = (lo_reg > hi_reg);

    // table write straight from the accepted request
    assign wr_en   = accept && (req.cmd == CMD_WRITE)
                     && ({22'd0, req.entry_index} < TABLE_DEPTH);
    assign wr_addr = ADDR_W'(req.entry_index);
    assign wr_data = req.data_value;

    assign rd_en   = (state_reg == S_READ) && !range_empty;
    assign rd_addr = ADDR_W'($unsigned(mid));

    always_comb
    begin
        unique case (cmd_reg)
            CMD_LOWER: qual = !(rd_data < key_reg);
            CMD_UPPER: qual = (key_reg < rd_data);
            CMD_FLOOR: qual = !(key_reg < rd_data);
            default:   qual = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        n_next       = n_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        ans_idx_next = ans_idx_reg;
        ans_val_next = ans_val_reg;
        hit_next     = hit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.cmd != CMD_WRITE)
                begin
                    cmd_next     = req.cmd;
                    key_next     = req.data_value;
                    lo_next      = $signed({{(POS_W-IDX_W){1'b0}}, req.search_low});
                    hi_next      = (hi_in > n_m1) ? n_m1 : hi_in;
                    n_next       = $signed({{(POS_W-CNT_W){1'b0}}, n_eff});
                    ans_idx_next = (req.cmd == CMD_FLOOR) ? '0 : n_eff;
                    ans_val_next = '0;
                    hit_next     = 1'b0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                if (range_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (qual)
                begin
                    hit_next     = 1'b1;
                    ans_idx_next = mid_reg[CNT_W-1:0];
                    if (cmd_reg == CMD_FLOOR)
                    begin
                        ans_val_next = rd_data;
                    end
                end
                // floor walks right on a hit, bounds walk left
                if (qual != (cmd_reg == CMD_FLOOR))
                begin
                    hi_next = mid_reg - POS_W'(1);
                end
                else
                begin
                    lo_next = mid_reg + POS_W'(1);
                end
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        n_reg       <= n_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        ans_idx_reg <= ans_idx_next;
        ans_val_reg <= ans_val_next;
        hit_reg     <= hit_next;
    end

    assign res_valid          = (state_reg == S_DONE);
    assign res.result_index   = ans_idx_reg;
    assign res.result_value   = ans_val_reg;
    assign res.found          = hit_reg;

    `SBS_ASSERT_IMP(a_hi_below_count, state_reg == S_READ && !range_empty, hi_reg < n_reg, "probe range passes the element count")
    `SBS_ASSERT_IMP(a_mid_in_range, state_reg == S_READ && !range_empty, mid >= lo_reg && mid <= hi_reg, "probe index outside the range")
    `SBS_ASSERT_NXT(a_read_then_cmp, state_reg == S_READ && !range_empty, state_reg == S_CMP, "probe read not followed by compare")

endmodule

@@ hdl/sorted_table_bound_search_top.sv @@
// top level of the sorted table bound search
// depends on sbs_pkg, assert_macros.svh, sbs_table, sbs_search
//
// usage:
//   s_* carries requests: s_tuser is the command (write, lower bound, upper
//   bound, floor), s_tdata the index, value or key and the search range.
//   a write request stores its value and gives no result. each query gives
//   one result on m_*: index, value and a found flag in m_tuser.
//   cfg_* writes element_count; only while no request is in flight.
// sequencing:
//   a write is stored as it is accepted. a query makes one probe of the table
//   memory per halving step (synchronous read, then compare), then hands its
//   result to the output register. one request is in flight at a time.
// reset:
//   rst_n clears control and element_count; table contents stay undefined
//   until written, so queries must only probe written entries.
// stall:
//   the result sits in an output register; while m_tready is low the next
//   request is still taken and runs until its own result is ready to load.
`include "assert_macros.svh"
module sorted_table_bound_search_top
    import sbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: element_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_index, data_value, search_low, search_high, pad
    input  logic [1:0]  s_tuser,   // cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_index, result_value, pad
    output logic        m_tuser    // found
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CNT_W-1:0]        count_reg;
    logic                    m_tvalid_reg;
    logic [CNT_W-1:0]        out_index_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_found_reg;

    request_t                req;
    result_t                 res;
    logic                    res_valid;
    logic                    res_ready;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // unpack the request
    assign req.cmd         = cmd_t'(s_tuser);
    assign req.entry_index = s_tdata[9:0];
    assign req.data_value  = $signed(s_tdata[41:10]);
    assign req.search_low  = s_tdata[51:42];
    assign req.search_high = s_tdata[61:52];

    sbs_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (count_reg),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req           (req),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // output register: loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_index_reg <= res.result_index;
            out_value_reg <= res.result_value;
            out_found_reg <= res.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_value_reg, out_index_reg};
    assign m_tuser  = out_found_reg;

    `SBS_ASSERT_IMP(a_hit_below_count, m_tvalid_reg && out_found_reg, out_index_reg < count_reg, "found index not below element count")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// self-checking bench for sorted_table_bound_search_top: fills the top of the table,
// sweeps element_count settings and checks every bound and floor result against a model
// depends on sbs_pkg and the rtl of sorted_table_bound_search_top
module tb;
    import sbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    // only the top window of the table is written; every probed range starts in it
    localparam int FILL_SIZE = 160;
    localparam int FILL_BASE = TABLE_DEPTH - FILL_SIZE;
    // a deep query plus handoff; also the wait after the last result
    localparam int SETTLE_CYCLES = 40;
    // cycles with no handshake on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT = 10;
    localparam int ITEMS_PER_PHASE = 26;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // expected-result store with its own copy of the table and element_count
    class bound_search_scoreboard;
        logic signed [VAL_W-1:0] entries [TABLE_DEPTH];
        logic [CNT_W-1:0]        element_count;
        result_t                 expected_results [$];
        int                      errors;

        function new();
            element_count = '0;
            errors = 0;
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // accepted request: store a write, or run the halving probe for a query
        function void note_request(request_t req);
            result_t                 r;
            int                      n;
            int                      lo;
            int                      hi;
            int                      mid;
            logic signed [VAL_W-1:0] key;
            logic signed [VAL_W-1:0] v;
            bit                      take;
            key = req.data_value;
            if (req.cmd == CMD_WRITE)
            begin
                entries[req.entry_index] = key;
                return;
            end
            n = (element_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(element_count);
            lo = int'(req.search_low);
            hi = int'(req.search_high);
            if (hi > n - 1)
            begin
                hi = n - 1;
            end
            r.result_index = (req.cmd == CMD_FLOOR) ? '0 : CNT_W'(n);
            r.result_value = '0;
            r.found = 1'b0;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                v = entries[mid];
                case (req.cmd)
                    CMD_FLOOR: take = (v <= key);
                    CMD_LOWER: take = (v >= key);
                    default:   take = (v > key);
                endcase
                if (take)
                begin
                    r.found = 1'b1;
                    r.result_index = CNT_W'(mid);
                    if (req.cmd == CMD_FLOOR)
                    begin
                        r.result_value = v;
                    end
                end
                // floor moves right on a hit, the bounds move left
                if (take == (req.cmd == CMD_FLOOR))
                begin
                    lo = mid + 1;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: index %0d value %0d found %0b",
                         $time, got.result_index, $signed(got.result_value), got.found);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.result_index !== want.result_index)
            begin
                $display("%0t: result_index expected %0d actual %0d",
                         $time, want.result_index, got.result_index);
                errors++;
            end
            if (got.result_value !== want.result_value)
            begin
                $display("%0t: result_value expected %0d actual %0d",
                         $time, $signed(want.result_value), $signed(got.result_value));
                errors++;
            end
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata = '0;  // entry_index, data_value, search_low, search_high, pad
    logic [1:0]       s_tuser = '0;  // cmd
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [47:0]      m_tdata;       // result_index, result_value, pad
    logic             m_tuser;       // found

    bound_search_scoreboard sb = new();

    // no gaps on either side while set
    bit quiet_run = 1'b0;
    int ready_hold = 0;
    int idle_cycles = 0;

    // entries overwritten out of order, restored newest first
    int                      broken_idx [$];
    logic signed [VAL_W-1:0] broken_val [$];

    sorted_table_bound_search_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet_run)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // result side backpressure
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
        end
        else if (quiet_run || $urandom_range(0, 2) != 0)
        begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 10);
        end
        else
        begin
            m_tready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result({m_tdata[10:0], m_tdata[42:11], m_tuser});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input cmd_t cmd, input logic [IDX_W-1:0] eidx,
                                input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] lo,
                                input logic [IDX_W-1:0] hi);
        int       gap;
        request_t req;
        gap = pick_gap();
        req = '{cmd: cmd, entry_index: eidx, data_value: val, search_low: lo,
                search_high: hi};
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, hi, lo, val, eidx};
        do @(posedge clk); while (!s_tready);
        sb.note_request(req);
    endtask

    task automatic write_entry(input int idx, input logic [VAL_W-1:0] val);
        send_request(CMD_WRITE, IDX_W'(idx), val, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic query(input cmd_t cmd, input logic [VAL_W-1:0] key, input int lo,
                         input int hi);
        send_request(cmd, IDX_W'($urandom), key, IDX_W'(lo), IDX_W'(hi));
    endtask

    // hold requests until every result is back and the block has settled
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.element_count = count;
    endtask

    // ascending values over the window, minimum to maximum, with runs of duplicates
    task automatic fill_table();
        longint level;
        level = VAL_MIN;
        for (int i = FILL_BASE; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
            begin
                level = VAL_MAX;
            end
            else if (i > FILL_BASE && $urandom_range(0, 3) != 0)
            begin
                level += $urandom_range(1, 10000000);
            end
            if (level > VAL_MAX)
            begin
                level = VAL_MAX;
            end
            write_entry(i, level[31:0]);
        end
    endtask

    task automatic restore_table();
        while (broken_idx.size() != 0)
        begin
            write_entry(broken_idx.pop_front(), broken_val.pop_front());
        end
    endtask

    // every query range starts inside the written window, so probes stay in it
    task automatic random_item();
        int                      r;
        int                      idx;
        int                      n;
        int                      a;
        int                      b;
        int                      lo;
        int                      hi;
        longint                  lo_nb;
        longint                  hi_nb;
        logic signed [VAL_W-1:0] key;
        cmd_t                    cmd;
        n = (sb.element_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.element_count);
        r = $urandom_range(0, 99);
        idx = $urandom_range(FILL_BASE, TABLE_DEPTH - 1);
        if (r < 12)
        begin
            // rewrite keeping the order with both neighbors
            lo_nb = (idx == FILL_BASE) ? longint'(VAL_MIN) : longint'(sb.entries[idx - 1]);
            hi_nb = (idx == TABLE_DEPTH - 1) ? longint'(VAL_MAX) : longint'(sb.entries[idx + 1]);
            if (lo_nb <= hi_nb)
            begin
                lo_nb += longint'($urandom) % (hi_nb - lo_nb + 1);
                write_entry(idx, lo_nb[31:0]);
            end
            else
            begin
                write_entry(idx, sb.entries[idx]);
            end
        end
        else if (r < 15)
        begin
            // break the order for a while
            broken_idx.push_front(idx);
            broken_val.push_front(sb.entries[idx]);
            write_entry(idx, $urandom);
        end
        else
        begin
            cmd = cmd_t'($urandom_range(1, 3));
            a = $urandom_range(0, 99);
            b = (n > FILL_BASE) ? $urandom_range(FILL_BASE, n - 1)
                                : $urandom_range(FILL_BASE, TABLE_DEPTH - 1);
            if (a < 50)
            begin
                key = sb.entries[b];
            end
            else if (a < 70)
            begin
                key = ($urandom_range(0, 1) != 0) ? sb.entries[b] + 1 : sb.entries[b] - 1;
            end
            else if (a < 85)
            begin
                key = $urandom;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       key = VAL_MIN;
                    1:       key = VAL_MAX;
                    2:       key = 0;
                    default: key = -1;
                endcase
            end
            a = $urandom_range(0, 99);
            if (a < 45)
            begin
                lo = FILL_BASE;
                hi = TABLE_DEPTH - 1;
            end
            else if (a < 80 && n > FILL_BASE)
            begin
                lo = $urandom_range(FILL_BASE, n - 1);
                hi = $urandom_range(FILL_BASE, n - 1);
                if (lo > hi)
                begin
                    b = lo;
                    lo = hi;
                    hi = b;
                end
                // range end past the element count now and then
                if ($urandom_range(0, 1) != 0)
                begin
                    hi = $urandom_range(hi, TABLE_DEPTH - 1);
                end
            end
            else if (a < 93)
            begin
                // start anywhere in the window, empty ranges included
                lo = $urandom_range(FILL_BASE, TABLE_DEPTH - 1);
                hi = $urandom_range(0, TABLE_DEPTH - 1);
            end
            else
            begin
                lo = (n > FILL_BASE) ? $urandom_range(FILL_BASE, n - 1)
                                     : $urandom_range(FILL_BASE, TABLE_DEPTH - 1);
                hi = lo;
            end
            query(cmd, key, lo, hi);
        end
    endtask

    initial
    begin
        logic signed [VAL_W-1:0] saved;
        int                      count;
        int                      first_probe;

        first_probe = FILL_BASE + (FILL_SIZE - 1) / 2;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing is probed, nothing found
        write_count('0);
        query(CMD_LOWER, 0, 0, TABLE_DEPTH - 1);
        query(CMD_UPPER, VAL_MAX, 0, TABLE_DEPTH - 1);
        query(CMD_FLOOR, VAL_MIN, 0, TABLE_DEPTH - 1);

        // the window is written before any probe can reach it
        fill_table();
        wait_drained();
        write_count(CNT_W'(TABLE_DEPTH));
        query(CMD_LOWER, VAL_MIN, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_LOWER, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_UPPER, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_UPPER, VAL_MIN, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_FLOOR, VAL_MIN, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_FLOOR, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_LOWER, sb.entries[950], FILL_BASE, TABLE_DEPTH - 1);
        // floor with nothing at or below the key inside the range
        query(CMD_FLOOR, sb.entries[900] - 1, 900, TABLE_DEPTH - 1);
        // empty range, then a single-entry range
        query(CMD_LOWER, 0, 900, 100);
        query(CMD_FLOOR, VAL_MAX, TABLE_DEPTH - 1, TABLE_DEPTH - 1);

        // range end past a short table
        wait_drained();
        write_count(CNT_W'(FILL_BASE + 5));
        query(CMD_LOWER, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_FLOOR, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_UPPER, sb.entries[FILL_BASE + 2], FILL_BASE + 3, TABLE_DEPTH - 1);

        // count above depth acts as the depth
        wait_drained();
        write_count(CNT_W'(2047));
        query(CMD_UPPER, VAL_MAX, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_LOWER, sb.entries[TABLE_DEPTH - 1], FILL_BASE, TABLE_DEPTH - 1);

        // unsorted table: the probe sequence is reported as it falls
        wait_drained();
        write_count(CNT_W'(TABLE_DEPTH));
        saved = sb.entries[first_probe];
        write_entry(first_probe, VAL_MAX);
        query(CMD_LOWER, sb.entries[1000], FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_FLOOR, 0, FILL_BASE, TABLE_DEPTH - 1);
        query(CMD_UPPER, sb.entries[880], FILL_BASE, TABLE_DEPTH - 1);
        write_entry(first_probe, saved);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       count = FILL_BASE + 1;
                1:       count = FILL_BASE + 2;
                2:       count = $urandom_range(FILL_BASE + 3, FILL_BASE + 16);
                3:       count = TABLE_DEPTH;
                4:       count = $urandom_range(FILL_BASE + 17, TABLE_DEPTH - 1);
                5:       count = $urandom_range(TABLE_DEPTH + 1, 2046);
                6:       count = 2047;
                // window lies past the count: nothing found
                7:       count = $urandom_range(1, FILL_BASE);
                8:       count = TABLE_DEPTH - 1;
                default: count = 0;
            endcase
            wait_drained();
            write_count(CNT_W'(count));
            quiet_run = (p == 3) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                random_item();
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_drained();
                end
            end
            restore_table();
        end

        quiet_run = 1'b0;
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
